@@ rtl/graph_walker_step_assert.svh @@
// assertion macros for the walker block
`ifndef GRAPH_WALKER_STEP_ASSERT_SVH
`define GRAPH_WALKER_STEP_ASSERT_SVH

// same-cycle implication
`define GWS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GWS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gws_pkg.sv @@
package gws_pkg;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int MAX_LINES_DEF  = 4096;
    localparam int MAX_DEGREE_DEF = 16;

    localparam int RND_W     = 31;
    localparam int DIV_W_DEF = $clog2(MAX_LINES_DEF + 1);

    localparam logic [2:0] CMD_STEP      = 3'd0;
    localparam logic [2:0] CMD_LOAD_NODE = 3'd1;
    localparam logic [2:0] CMD_LOAD_LINE = 3'd2;
    localparam logic [2:0] CMD_READ_ARR  = 3'd3;
    localparam logic [2:0] CMD_READ_FLUX = 3'd4;

    localparam logic [1:0] RULE_RANDOM = 2'd0;
    localparam logic [1:0] RULE_JUMP   = 2'd1;
    localparam logic [1:0] RULE_STAY   = 2'd2;
    localparam logic [1:0] RULE_PROPEL = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_NONEIGH = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_LINE_COUNT = 1'b1;

endpackage

@@ rtl/gws_if.sv @@
interface gws_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [1:0]  rule;
    logic [9:0]  src_node;
    logic [9:0]  prev_node;
    logic [15:0] walker_id;
    logic [30:0] random_value;
    logic [11:0] entry_index;
    logic [4:0]  degree_value;
    logic [11:0] first_line_value;
    logic [9:0]  target_value;

    modport source (output valid, command, rule, src_node, prev_node, walker_id,
                    random_value, entry_index, degree_value, first_line_value,
                    target_value, input ready);
    modport sink (input valid, command, rule, src_node, prev_node, walker_id,
                  random_value, entry_index, degree_value, first_line_value,
                  target_value, output ready);
endinterface

interface gws_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  new_node;
    logic [15:0] walker_tag;
    logic [31:0] counter_value;

    modport source (output valid, status, new_node, walker_tag, counter_value,
                    input ready);
    modport sink (input valid, status, new_node, walker_tag, counter_value,
                  output ready);
endinterface

@@ rtl/gws_mod.sv @@
module gws_mod import gws_pkg::*; #(
    parameter int DIV_W = DIV_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RND_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_div,
    output logic             o_done,
    output logic [DIV_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(RND_W);

    logic [RND_W-1:0] r_num;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;

    // one remainder bit per cycle
    always_comb begin
        w_trial = {r_rem, r_num[RND_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_div <= i_div;
            r_rem <= '0;
            r_cnt <= CNT_W'(RND_W - 1);
        end else if (r_busy) begin
            r_num <= {r_num[RND_W-2:0], 1'b0};
            r_rem <= (w_trial >= {1'b0, r_div}) ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/gws_cfg.sv @@
module gws_cfg import gws_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [10:0] o_node_count,
    output logic [12:0] o_line_count
);

    logic [10:0] r_node_count;
    logic [12:0] r_line_count;
    logic        w_wr;

    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_line_count <= '0;
        end else if (w_wr) begin
            case (paddr[2])
                REG_NODE_COUNT: r_node_count <= pwdata[10:0];
                REG_LINE_COUNT: r_line_count <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NODE_COUNT: prdata = 32'(r_node_count);
            REG_LINE_COUNT: prdata = 32'(r_line_count);
            default:        prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign o_node_count = r_node_count;
    assign o_line_count = r_line_count;

endmodule

@@ rtl/graph_walker_step.sv @@
// channel  dir  modport  payload
// i_in     in   sink     command rule src_node prev_node walker_id random_value
//                        entry_index degree_value first_line_value target_value
// o_out    out  source   status new_node walker_tag counter_value
// apb      in   slave    node_count (0x0), line_count (0x4)
//
// one item at a time; loads and bad commands go straight to S_OUT, reads via S_RDCNT
// sleep bumps the arrival counter; teleport and random use the shared remainder unit
// propulsion: two scans over the node's lines, one read each, the second up to the pick
// after reset a clearing pass over max(MAX_NODES, MAX_LINES) entries zeroes counters
// a result waits in the output register until taken; the next item then holds in S_OUT
`include "graph_walker_step_assert.svh"

module graph_walker_step import gws_pkg::*; #(
    parameter int MAX_NODES  = MAX_NODES_DEF,
    parameter int MAX_LINES  = MAX_LINES_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gws_in_if.sink      i_in,
    gws_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int LW   = $clog2(MAX_LINES);
    localparam int DGW  = $clog2(MAX_DEGREE + 1);
    localparam int DW   = $clog2(MAX_LINES + 1);
    localparam int CLRN = (MAX_NODES > MAX_LINES) ? MAX_NODES : MAX_LINES;
    localparam int CLW  = $clog2(CLRN);
    localparam int NMW  = 12 + DGW;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_RDCNT    = 14'b00000000000100,
        S_NODE     = 14'b00000000001000,
        S_SCAN_RD  = 14'b00000000010000,
        S_SCAN_CMP = 14'b00000000100000,
        S_MOD      = 14'b00000001000000,
        S_SEL_RD   = 14'b00000010000000,
        S_SEL_CMP  = 14'b00000100000000,
        S_FLUX_RD  = 14'b00001000000000,
        S_FLUX_WR  = 14'b00010000000000,
        S_ARR_RD   = 14'b00100000000000,
        S_ARR_WR   = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [10:0] w_node_count;
    logic [12:0] w_line_count;
    logic [31:0] w_lim32;

    logic [CLW-1:0]   r_clr, n_clr;
    logic [1:0]       r_rule, n_rule;
    logic [9:0]       r_from, n_from;
    logic [9:0]       r_prev, n_prev;
    logic [15:0]      r_tag, n_tag;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [11:0]      r_first, n_first;
    logic [DGW-1:0]   r_deg, n_deg;
    logic [DGW-1:0]   r_i, n_i;
    logic [DW-1:0]    r_cnt, n_cnt;
    logic [DW-1:0]    r_pick, n_pick;
    logic [LW-1:0]    r_line, n_line;
    logic [9:0]       r_dest, n_dest;
    logic             r_do_flux, n_do_flux;
    logic             r_rd_flux, n_rd_flux;
    logic [1:0]       r_status, n_status;
    logic [9:0]       r_new_node, n_new_node;
    logic [31:0]      r_counter, n_counter;
    logic             r_oval, n_oval;
    logic [1:0]       r_o_status, n_o_status;
    logic [9:0]       r_o_node, n_o_node;
    logic [15:0]      r_o_tag, n_o_tag;
    logic [31:0]      r_o_counter, n_o_counter;

    logic [NMW-1:0] r_node_mem [MAX_NODES];
    logic [9:0]     r_tgt_mem  [MAX_LINES];
    logic [31:0]    r_flux_mem [MAX_LINES];
    logic [31:0]    r_arr_mem  [MAX_NODES];
    logic [NMW-1:0] r_node_rd;
    logic [9:0]     r_tgt_rd;
    logic [31:0]    r_flux_rd;
    logic [31:0]    r_arr_rd;

    logic           w_node_we;
    logic [NW-1:0]  w_node_wa;
    logic [NMW-1:0] w_node_wd;
    logic [NW-1:0]  w_node_ra;
    logic           w_tgt_we;
    logic [LW-1:0]  w_tgt_wa;
    logic [LW-1:0]  w_tgt_ra;
    logic           w_flux_we;
    logic [LW-1:0]  w_flux_wa;
    logic [31:0]    w_flux_wd;
    logic [LW-1:0]  w_flux_ra;
    logic           w_arr_we;
    logic [NW-1:0]  w_arr_wa;
    logic [31:0]    w_arr_wd;
    logic [NW-1:0]  w_arr_ra;

    logic             w_div_start;
    logic [RND_W-1:0] w_div_num;
    logic [DW-1:0]    w_div_d;
    logic             w_div_done;
    logic [DW-1:0]    w_div_rem;

    logic           w_in_beat;
    logic [LW-1:0]  w_scan_line;
    logic           w_hit;
    logic [DGW-1:0] w_i_nx;
    logic [DW-1:0]  w_cnt_nx;
    logic [DGW-1:0] w_ndeg;
    logic [11:0]    w_nfirst;
    logic [DGW-1:0] w_degv;
    logic           w_from_ok;

    gws_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_node_count (w_node_count),
        .o_line_count (w_line_count)
    );

    gws_mod #(.DIV_W(DW)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_div   (w_div_d),
        .o_done  (w_div_done),
        .o_rem   (w_div_rem)
    );

    assign w_lim32 = (32'(w_line_count) < 32'(MAX_LINES)) ? 32'(w_line_count)
                                                          : 32'(MAX_LINES);
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in.valid && i_in.ready;
    assign w_div_num  = (r_state == S_IDLE) ? i_in.random_value : r_rnd;

    assign w_scan_line = LW'(32'(r_first) + 32'(r_i));
    assign w_hit       = (r_tgt_rd != r_prev);
    assign w_i_nx      = r_i + DGW'(1);
    assign w_cnt_nx    = r_cnt + DW'(w_hit);
    assign w_ndeg      = r_node_rd[DGW-1:0];
    assign w_nfirst    = r_node_rd[NMW-1:DGW];
    assign w_degv      = (32'(i_in.degree_value) > 32'(MAX_DEGREE)) ? DGW'(MAX_DEGREE)
                                                                    : DGW'(i_in.degree_value);
    assign w_from_ok   = (32'(i_in.src_node) < 32'(w_node_count))
                         && (32'(i_in.src_node) < 32'(MAX_NODES));

    // memory ports
    always_comb begin
        w_node_we = w_in_beat && (i_in.command == CMD_LOAD_NODE)
                    && (32'(i_in.entry_index) < 32'(MAX_NODES));
        w_node_wa = NW'(i_in.entry_index);
        w_node_wd = {i_in.first_line_value, w_degv};
        w_node_ra = NW'(i_in.src_node);
        w_tgt_we  = w_in_beat && (i_in.command == CMD_LOAD_LINE)
                    && (32'(i_in.entry_index) < 32'(MAX_LINES));
        w_tgt_wa  = LW'(i_in.entry_index);
        w_tgt_ra  = (r_state == S_FLUX_RD) ? r_line : w_scan_line;
        w_flux_ra = (r_state == S_IDLE) ? LW'(i_in.entry_index) : r_line;
        w_arr_ra  = (r_state == S_IDLE) ? NW'(i_in.entry_index) : NW'(r_dest);
        if (r_state == S_CLEAR) begin
            w_flux_we = (32'(r_clr) < 32'(MAX_LINES));
            w_flux_wa = LW'(r_clr);
            w_flux_wd = '0;
            w_arr_we  = (32'(r_clr) < 32'(MAX_NODES));
            w_arr_wa  = NW'(r_clr);
            w_arr_wd  = '0;
        end else begin
            w_flux_we = (r_state == S_FLUX_WR) && r_do_flux;
            w_flux_wa = r_line;
            w_flux_wd = (r_flux_rd == '1) ? r_flux_rd : r_flux_rd + 32'd1;
            w_arr_we  = (r_state == S_ARR_WR) && (32'(r_dest) < 32'(MAX_NODES));
            w_arr_wa  = NW'(r_dest);
            w_arr_wd  = (r_arr_rd == '1) ? r_arr_rd : r_arr_rd + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_wa] <= w_node_wd;
        end
        r_node_rd <= r_node_mem[w_node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_tgt_we) begin
            r_tgt_mem[w_tgt_wa] <= i_in.target_value;
        end
        r_tgt_rd <= r_tgt_mem[w_tgt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_flux_we) begin
            r_flux_mem[w_flux_wa] <= w_flux_wd;
        end
        r_flux_rd <= r_flux_mem[w_flux_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_arr_we) begin
            r_arr_mem[w_arr_wa] <= w_arr_wd;
        end
        r_arr_rd <= r_arr_mem[w_arr_ra];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_rule      = r_rule;
        n_from      = r_from;
        n_prev      = r_prev;
        n_tag       = r_tag;
        n_rnd       = r_rnd;
        n_first     = r_first;
        n_deg       = r_deg;
        n_i         = r_i;
        n_cnt       = r_cnt;
        n_pick      = r_pick;
        n_line      = r_line;
        n_dest      = r_dest;
        n_do_flux   = r_do_flux;
        n_rd_flux   = r_rd_flux;
        n_status    = r_status;
        n_new_node  = r_new_node;
        n_counter   = r_counter;
        n_oval      = r_oval && !o_out.ready;
        n_o_status  = r_o_status;
        n_o_node    = r_o_node;
        n_o_tag     = r_o_tag;
        n_o_counter = r_o_counter;
        w_div_start = 1'b0;
        w_div_d     = DW'(w_lim32);

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + CLW'(1);
                if (32'(r_clr) == CLRN - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_beat) begin
                    n_rule     = i_in.rule;
                    n_from     = i_in.src_node;
                    n_prev     = i_in.prev_node;
                    n_tag      = i_in.walker_id;
                    n_rnd      = i_in.random_value;
                    n_rd_flux  = (i_in.command == CMD_READ_FLUX);
                    n_new_node = '0;
                    n_counter  = '0;
                    n_status   = ST_BAD;
                    n_state    = S_OUT;
                    case (i_in.command)
                        CMD_STEP: begin
                            n_new_node = i_in.src_node;
                            n_dest     = i_in.src_node;
                            if (!w_from_ok) begin
                                n_status = ST_RANGE;
                            end else if (i_in.rule == RULE_STAY) begin
                                n_state = S_ARR_RD;
                            end else if (i_in.rule == RULE_JUMP) begin
                                if (w_lim32 != '0) begin
                                    w_div_start = 1'b1;
                                    n_state     = S_MOD;
                                end
                            end else begin
                                n_state = S_NODE;
                            end
                        end
                        CMD_LOAD_NODE: begin
                            if (32'(i_in.entry_index) < 32'(MAX_NODES)) begin
                                n_status = ST_OK;
                            end
                        end
                        CMD_LOAD_LINE: begin
                            if (32'(i_in.entry_index) < 32'(MAX_LINES)) begin
                                n_status = ST_OK;
                            end
                        end
                        CMD_READ_ARR: begin
                            if (32'(i_in.entry_index) < 32'(MAX_NODES)) begin
                                n_status = ST_OK;
                                n_state  = S_RDCNT;
                            end
                        end
                        CMD_READ_FLUX: begin
                            if (32'(i_in.entry_index) < 32'(MAX_LINES)) begin
                                n_status = ST_OK;
                                n_state  = S_RDCNT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDCNT: begin
                n_counter = r_rd_flux ? r_flux_rd : r_arr_rd;
                n_state   = S_OUT;
            end
            S_NODE: begin
                n_first = w_nfirst;
                n_deg   = w_ndeg;
                n_i     = '0;
                n_cnt   = '0;
                if (w_ndeg == '0) begin
                    n_status = ST_NONEIGH;
                    n_state  = S_OUT;
                end else if (32'(w_nfirst) + 32'(w_ndeg) > w_lim32) begin
                    n_status = ST_BAD;
                    n_state  = S_OUT;
                end else if (r_rule == RULE_RANDOM) begin
                    w_div_start = 1'b1;
                    w_div_d     = DW'(w_ndeg);
                    n_state     = S_MOD;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                n_cnt = w_cnt_nx;
                n_i   = w_i_nx;
                if (w_i_nx == r_deg) begin
                    if (w_cnt_nx == '0) begin
                        n_dest  = r_from;
                        n_state = S_ARR_RD;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_d     = w_cnt_nx;
                        n_state     = S_MOD;
                    end
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_MOD: begin
                if (w_div_done) begin
                    case (r_rule)
                        RULE_JUMP: begin
                            n_line    = LW'(w_div_rem);
                            n_do_flux = 1'b0;
                            n_state   = S_FLUX_RD;
                        end
                        RULE_RANDOM: begin
                            n_line    = LW'(32'(r_first) + 32'(w_div_rem));
                            n_do_flux = 1'b1;
                            n_state   = S_FLUX_RD;
                        end
                        default: begin
                            n_pick  = w_div_rem;
                            n_i     = '0;
                            n_state = S_SEL_RD;
                        end
                    endcase
                end
            end
            S_SEL_RD: begin
                n_state = S_SEL_CMP;
            end
            S_SEL_CMP: begin
                n_i     = w_i_nx;
                n_state = S_SEL_RD;
                if (w_hit) begin
                    if (r_pick == '0) begin
                        n_line    = w_scan_line;
                        n_do_flux = 1'b1;
                        n_state   = S_FLUX_RD;
                    end else begin
                        n_pick = r_pick - DW'(1);
                    end
                end
            end
            S_FLUX_RD: begin
                n_state = S_FLUX_WR;
            end
            S_FLUX_WR: begin
                n_dest  = r_tgt_rd;
                n_state = S_ARR_RD;
            end
            S_ARR_RD: begin
                n_state = S_ARR_WR;
            end
            S_ARR_WR: begin
                n_status   = ST_OK;
                n_new_node = r_dest;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_oval || o_out.ready) begin
                    n_oval      = 1'b1;
                    n_o_status  = r_status;
                    n_o_node    = r_new_node;
                    n_o_tag     = r_tag;
                    n_o_counter = r_counter;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rule      <= n_rule;
        r_from      <= n_from;
        r_prev      <= n_prev;
        r_tag       <= n_tag;
        r_rnd       <= n_rnd;
        r_first     <= n_first;
        r_deg       <= n_deg;
        r_i         <= n_i;
        r_cnt       <= n_cnt;
        r_pick      <= n_pick;
        r_line      <= n_line;
        r_dest      <= n_dest;
        r_do_flux   <= n_do_flux;
        r_rd_flux   <= n_rd_flux;
        r_status    <= n_status;
        r_new_node  <= n_new_node;
        r_counter   <= n_counter;
        r_o_status  <= n_o_status;
        r_o_node    <= n_o_node;
        r_o_tag     <= n_o_tag;
        r_o_counter <= n_o_counter;
    end

    assign o_out.valid         = r_oval;
    assign o_out.status        = r_o_status;
    assign o_out.new_node      = r_o_node;
    assign o_out.walker_tag    = r_o_tag;
    assign o_out.counter_value = r_o_counter;

    `GWS_ASSERT_NXT(a_busy_after_beat, w_in_beat, !i_in.ready, "ready right after an input beat")
    `GWS_ASSERT_IMP(a_div_nonzero, w_div_start, w_div_d != '0, "remainder unit started with zero")
    `GWS_ASSERT_IMP(a_flux_in_range, w_flux_we && r_state == S_FLUX_WR, 32'(r_line) < w_lim32, "flux beyond lines in use")

endmodule
